/* rtl/core/pte_pkg.sv */
// ============================================================================
// pte_pkg
// Shared types and constants of the prefix trie engine: field widths,
// operation codes, parameter defaults and the clearing-pass control group.
// ============================================================================
package pte_pkg;

    localparam int NODE_COUNT_DEF    = 1024;
    localparam int ALPHABET_SIZE_DEF = 26;

    localparam int CMD_W    = 2;
    localparam int LETTER_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

    // control group from the clearing sweep
    typedef struct packed {
        logic busy;
        logic mark_we;
    } clr_ctl_t;

endpackage

/* rtl/core/pte_if.sv */
// ============================================================================
// pte_if
// Valid/ready channels of the prefix trie engine: letter requests in,
// word results out.
// ============================================================================
interface pte_in_if;
    logic                         valid;
    logic                         ready;
    logic [pte_pkg::CMD_W-1:0]    cmd;
    logic [pte_pkg::LETTER_W-1:0] letter;
    logic                         no_letter;
    logic                         last_letter;

    modport source (output valid, output cmd, output letter, output no_letter,
                    output last_letter, input ready);
    modport sink   (input valid, input cmd, input letter, input no_letter,
                    input last_letter, output ready);
endinterface

interface pte_out_if;
    logic valid;
    logic ready;
    logic found;
    logic overflow;

    modport source (output valid, output found, output overflow, input ready);
    modport sink   (input valid, input found, input overflow, output ready);
endinterface

/* rtl/core/pte_ram.sv */
// ============================================================================
// pte_ram
// Generic single-write, single-read synchronous RAM; read data registered
// and held while no read is issued.
// ============================================================================
module pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pte_clear.sv */
// ============================================================================
// pte_clear
// Post-reset sweep: walk every child-table entry once, zeroing it, and zero
// the end marks along the way.
// ============================================================================
module pte_clear #(
    parameter int NODE_COUNT    = pte_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = pte_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    output pte_pkg::clr_ctl_t                           ctl,
    output logic [$clog2(NODE_COUNT*ALPHABET_SIZE)-1:0] child_addr,
    output logic [$clog2(NODE_COUNT)-1:0]               mark_addr
);

    localparam int TOTAL = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW    = $clog2(TOTAL);
    localparam int NW    = $clog2(NODE_COUNT);

    logic [AW-1:0] count_reg;
    logic [AW-1:0] count_next;
    logic          busy_reg;
    logic          busy_next;

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        if (busy_reg)
        begin
            if (count_reg == AW'(TOTAL - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                count_next = count_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    assign ctl.busy    = busy_reg;
    assign ctl.mark_we = busy_reg && (count_reg < AW'(NODE_COUNT));
    assign child_addr  = count_reg;
    assign mark_addr   = count_reg[NW-1:0];

endmodule

/* rtl/core/prefix_trie_engine_core.sv */
// ============================================================================
// prefix_trie_engine_core
// Word trie over a fixed node pool: insert, exact search and prefix check,
// one letter per request transfer, one result transfer per word.
// ============================================================================
// Usage:
//   req carries one letter per transfer with its cmd (insert, search,
//   prefix), a last_letter mark and a no_letter flag for the empty word.
//   rsp carries one result (found, overflow) at the end of each word and
//   none for the other letters.
//   Each letter first reads the child table, then updates the cursor (and
//   allocates a node on insert). The last letter of a search then reads
//   the end mark, and the result goes into the output register from that
//   read; other word ends fill the output register in the cursor update.
//   A new letter is taken only once the block is through with the last
//   one: one letter in flight at most.
//   After reset the block sweeps both memories to zero; req.ready stays
//   low until the sweep is done.
//   When rsp stalls, the result is held; the next letters are still taken
//   while no further result is due, and a word end stalls until the output
//   register frees up.
// ============================================================================
module prefix_trie_engine_core #(
    parameter int NODE_COUNT    = pte_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = pte_pkg::ALPHABET_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pte_in_if.sink      req,
    pte_out_if.source   rsp
);

    localparam int TOTAL = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW    = $clog2(TOTAL);
    localparam int NW    = $clog2(NODE_COUNT);
    localparam logic [NW:0] POOL_END = (NW+1)'(NODE_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_MARK  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // walk state
    logic [NW-1:0] cursor_reg,      cursor_next;
    logic          walk_failed_reg, walk_failed_next;
    logic [NW:0]   next_free_reg,   next_free_next;

    // held request
    logic [pte_pkg::CMD_W-1:0] op_reg,     op_next;
    logic                      last_reg,   last_next;
    logic                      lookup_reg, lookup_next;
    logic [AW-1:0]             addr_reg,   addr_next;

    // output register
    logic out_valid_reg, out_valid_next;
    logic found_reg,     found_next;
    logic overflow_reg,  overflow_next;

    // clearing sweep
    pte_pkg::clr_ctl_t clr_ctl;
    logic [AW-1:0]     clr_child_addr;
    logic [NW-1:0]     clr_mark_addr;

    // memory ports
    logic          child_we, child_re;
    logic [AW-1:0] child_waddr, child_raddr;
    logic [NW-1:0] child_wdata, child_rdata;
    logic          mark_we, mark_re;
    logic [NW-1:0] mark_waddr, mark_raddr;
    logic          mark_wdata, mark_rdata;

    // lookup-stage decode
    logic          accept;
    logic          bad_letter;
    logic          out_free;
    logic          hit, alloc, fail;
    logic [NW-1:0] cur;
    logic          to_mark, look_commit;
    logic          is_insert, is_search;

    pte_clear #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_clear (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (clr_ctl),
        .child_addr (clr_child_addr),
        .mark_addr  (clr_mark_addr)
    );

    pte_ram #(
        .WIDTH (NW),
        .DEPTH (TOTAL)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    pte_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // a letter beyond the alphabet fails the walk for every operation
    assign bad_letter = (int'(req.letter) >= ALPHABET_SIZE);

    // Resolve the child read: follow, allocate or fail.
    assign is_insert = (op_reg == pte_pkg::CMD_INSERT);
    assign is_search = (op_reg == pte_pkg::CMD_SEARCH);
    assign hit   = lookup_reg && (child_rdata != '0);
    assign alloc = lookup_reg && (child_rdata == '0) && is_insert
                   && (next_free_reg < POOL_END);
    assign fail  = walk_failed_reg || (lookup_reg && !hit && !alloc);
    assign cur   = hit   ? child_rdata :
                   alloc ? next_free_reg[NW-1:0] : cursor_reg;

    // a search word end needs the end mark of the final node first
    assign to_mark     = last_reg && is_search && !fail;
    assign look_commit = !last_reg || to_mark || out_free;

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        walk_failed_next = walk_failed_reg;
        next_free_next   = next_free_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        lookup_next      = lookup_reg;
        addr_next        = addr_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        found_next       = found_reg;
        overflow_next    = overflow_reg;

        child_re    = 1'b0;
        child_raddr = addr_reg;
        mark_re     = 1'b0;
        mark_raddr  = cur;

        child_we    = 1'b0;
        child_waddr = addr_reg;
        child_wdata = next_free_reg[NW-1:0];
        mark_we     = 1'b0;
        mark_waddr  = cur;
        mark_wdata  = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                // zero both memories at the sweep address
                child_we    = clr_ctl.busy;
                child_waddr = clr_child_addr;
                child_wdata = '0;
                mark_we     = clr_ctl.mark_we;
                mark_waddr  = clr_mark_addr;
                mark_wdata  = 1'b0;
                if (!clr_ctl.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.cmd;
                    last_next   = req.last_letter || req.no_letter;
                    lookup_next = !walk_failed_reg && !req.no_letter && !bad_letter;
                    if (!walk_failed_reg && !req.no_letter && bad_letter)
                    begin
                        walk_failed_next = 1'b1;
                    end
                    addr_next   = AW'(cursor_reg) * AW'(ALPHABET_SIZE)
                                  + AW'(req.letter);
                    child_re    = lookup_next;
                    child_raddr = addr_next;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_commit)
                begin
                    // link a fresh node into the parent row
                    if (alloc)
                    begin
                        child_we       = 1'b1;
                        next_free_next = next_free_reg + (NW+1)'(1);
                    end
                    state_next = S_IDLE;
                    if (!last_reg)
                    begin
                        cursor_next      = cur;
                        walk_failed_next = fail;
                    end
                    else if (to_mark)
                    begin
                        cursor_next = cur;
                        mark_re     = 1'b1;
                        state_next  = S_MARK;
                    end
                    else
                    begin
                        if (is_insert && !fail)
                        begin
                            mark_we = 1'b1;
                        end
                        out_valid_next   = 1'b1;
                        found_next       = !fail;
                        overflow_next    = is_insert && fail;
                        cursor_next      = '0;
                        walk_failed_next = 1'b0;
                    end
                end
            end
            S_MARK:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = mark_rdata;
                    overflow_next    = 1'b0;
                    cursor_next      = '0;
                    walk_failed_next = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cursor_reg      <= '0;
            walk_failed_reg <= 1'b0;
            next_free_reg   <= (NW+1)'(1);
            out_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
            lookup_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            walk_failed_reg <= walk_failed_next;
            next_free_reg   <= next_free_next;
            out_valid_reg   <= out_valid_next;
            last_reg        <= last_next;
            lookup_reg      <= lookup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        found_reg    <= found_next;
        overflow_reg <= overflow_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = found_reg;
    assign rsp.overflow = overflow_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // a new result only comes out of the lookup or end-mark step
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(state_reg) == S_LOOK || $past(state_reg) == S_MARK)
    ) else $error("result raised outside the lookup or end-mark step");

    // the free counter never runs past the pool
    a_pool_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        next_free_reg <= POOL_END
    ) else $error("free counter beyond the node pool");

    // no request is taken while the sweep still owns the memories
    a_no_accept_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        req.ready |-> !clr_ctl.busy
    ) else $error("request ready during clearing sweep");

    // every allocation takes exactly one node
    a_alloc_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && look_commit && alloc)
            |=> (next_free_reg == $past(next_free_reg) + (NW+1)'(1))
    ) else $error("node allocation did not advance the free counter by one");

endmodule

/* tb/sv/pte_word_checker.sv */
// ============================================================================
// pte_word_checker
// Watches the letter and result channels of the prefix trie engine, keeps
// its own copy of the trie, predicts one answer per word and compares every
// result transfer against the oldest predicted answer.
// ============================================================================
module pte_word_checker
    import pte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pte_in_if    req,
    pte_out_if   rsp,
    output int   errors,
    output int   pending,
    output int   answers,
    output int   overflows,
    output int   hits
);

    localparam int NODES  = NODE_COUNT_DEF;
    localparam int ALPHA  = ALPHABET_SIZE_DEF;
    localparam int NODE_W = $clog2(NODES);

    typedef struct packed {
        logic found;
        logic overflow;
    } answer_t;

    logic [NODE_W-1:0] child_of [NODES*ALPHA];
    logic              word_end [NODES];
    logic [NODE_W:0]   free_node;
    logic [NODE_W-1:0] at_node;
    logic              dead_walk;
    answer_t           word_answers [$];
    int                fail_cnt;
    int                answer_cnt;
    int                ovf_cnt;
    int                hit_cnt;

    function automatic void note_failure(string msg);
        if (fail_cnt < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endfunction

    // Advance the walk by one letter transfer; queue an answer at a word end.
    task automatic trie_step(input logic [CMD_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic empty, input logic tail);
        int      slot;
        answer_t ans;
        if (!dead_walk && !empty)
        begin
            if (ltr >= ALPHA)
                dead_walk = 1'b1;
            else
            begin
                slot = int'(at_node) * ALPHA + int'(ltr);
                if (child_of[slot] != '0)
                    at_node = child_of[slot];
                else if (op == CMD_INSERT && free_node < NODES)
                begin
                    child_of[slot] = free_node[NODE_W-1:0];
                    at_node        = free_node[NODE_W-1:0];
                    free_node      = free_node + 1'b1;
                end
                else
                    dead_walk = 1'b1;
            end
        end
        if (empty || tail)
        begin
            ans = '0;
            if (op == CMD_INSERT)
            begin
                if (dead_walk)
                    ans.overflow = 1'b1;
                else
                begin
                    word_end[at_node] = 1'b1;
                    ans.found = 1'b1;
                end
            end
            else if (op == CMD_SEARCH)
                ans.found = !dead_walk && word_end[at_node];
            else
                ans.found = !dead_walk;  // prefix check, and the spare code too
            word_answers.push_back(ans);
            at_node   = '0;
            dead_walk = 1'b0;
        end
    endtask

    task automatic check_answer(input logic found, input logic overflow);
        answer_t want;
        if (word_answers.size() == 0)
        begin
            note_failure($sformatf("result found=%0b overflow=%0b with no word pending",
                                   found, overflow));
            return;
        end
        want = word_answers.pop_front();
        answer_cnt++;
        if (found !== want.found)
            note_failure($sformatf("found: expected %0b, got %0b", want.found, found));
        if (overflow !== want.overflow)
            note_failure($sformatf("overflow: expected %0b, got %0b",
                                   want.overflow, overflow));
        if (overflow === 1'b1)
            ovf_cnt++;
        if (found === 1'b1)
            hit_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES*ALPHA; i++)
                child_of[i] = '0;
            for (int i = 0; i < NODES; i++)
                word_end[i] = 1'b0;
            free_node = (NODE_W+1)'(1);
            at_node   = '0;
            dead_walk = 1'b0;
            word_answers.delete();
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_answer(rsp.found, rsp.overflow);
            if (req.valid === 1'b1 && req.ready === 1'b1)
                trie_step(req.cmd, req.letter, req.no_letter, req.last_letter);
        end
        errors    <= fail_cnt;
        pending   <= word_answers.size();
        answers   <= answer_cnt;
        overflows <= ovf_cnt;
        hits      <= hit_cnt;
    end

endmodule

/* tb/sv/tb_prefix_trie_engine_core.sv */
// ============================================================================
// tb_prefix_trie_engine_core
// Drives words into the prefix trie engine letter by letter under random
// idling on both channels, with one long result hold-off, and gives the
// verdict from the failure count and the pending count of the word checker.
// ============================================================================
module tb_prefix_trie_engine_core;
    import pte_pkg::*;

    // The spare command code behaves as a prefix check.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 530;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_LEN      = 12;
    localparam int TIME_LIMIT   = 4_000_000;

    typedef struct packed {
        logic [MAX_LEN-1:0][LETTER_W-1:0] ltr;
        logic [3:0]                       len;
    } word_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  calm;        // suppresses idling on both sides
    logic  start_hold;  // kicks off the long result hold-off
    logic  hold_rsp;
    int    sent;
    word_t stored [$];  // words already offered for insert, reused for lookups

    int n_errors;
    int n_pending;
    int n_answers;
    int n_overflows;
    int n_hits;

    pte_in_if  req_if ();
    pte_out_if rsp_if ();

    prefix_trie_engine_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pte_word_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .errors    (n_errors),
        .pending   (n_pending),
        .answers   (n_answers),
        .overflows (n_overflows),
        .hits      (n_hits)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Letter channel
    // ------------------------------------------------------------------------

    // Offer one letter and hold it until the transfer happens. Drop valid for
    // random idle cycles first, unless the calm window is open.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic empty, input logic tail);
        while (!calm && $urandom_range(99) < 33)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= op;
        req_if.letter      <= ltr;
        req_if.no_letter   <= empty;
        req_if.last_letter <= tail;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        sent++;
    endtask

    // Send a whole word with one command; a zero length becomes the empty word.
    task automatic send_word(input logic [CMD_W-1:0] op, input word_t w);
        for (int k = 0; k < w.len; k++)
            send_item(op, w.ltr[k], 1'b0, k == w.len - 1);
        if (w.len == 0)
            send_item(op, LETTER_W'($urandom), 1'b1, 1'b1);
    endtask

    function automatic word_t spell(string s);
        word_t w;
        w = '0;
        w.len = 4'(s.len());
        for (int k = 0; k < s.len(); k++)
            w.ltr[k] = LETTER_W'(s[k] - "a");
        return w;
    endfunction

    // Narrow letters most of the time so that words share prefixes and
    // lookups hit; wide draws spread over the whole alphabet.
    function automatic word_t pick_word(int max_len, bit wide);
        word_t w;
        w = '0;
        w.len = 4'($urandom_range(max_len, 1));
        for (int k = 0; k < w.len; k++)
            w.ltr[k] = (wide || $urandom_range(99) < 30) ? LETTER_W'($urandom_range(25))
                                                         : LETTER_W'($urandom_range(3));
        return w;
    endfunction

    // Take a stored word, possibly cut short or with one extra letter.
    function automatic word_t pick_stored();
        word_t w;
        w = stored[$urandom_range(stored.size() - 1)];
        if ($urandom_range(99) < 30)
            w.len = 4'($urandom_range(w.len, 1));
        else if ($urandom_range(99) < 15 && w.len < MAX_LEN)
        begin
            w.ltr[w.len] = LETTER_W'($urandom_range(3));
            w.len = w.len + 1'b1;
        end
        return w;
    endfunction

    // Broken sequences: any command per letter, letters past the alphabet,
    // empty-word flags in the middle. The last letter always closes the word.
    task automatic send_noise();
        int n;
        n = $urandom_range(5, 1);
        for (int k = 0; k < n; k++)
            send_item(CMD_W'($urandom_range(3)), LETTER_W'($urandom_range(31)),
                      $urandom_range(99) < 15, k == n - 1);
    endtask

    task automatic send_random_word();
        int    roll;
        word_t w;
        roll = $urandom_range(99);
        if (roll < 35 || stored.size() == 0)
        begin
            w = pick_word(6, 1'b0);
            send_word(CMD_INSERT, w);
            if (stored.size() < 200)
                stored.push_back(w);
        end
        else if (roll < 55)
            send_word(CMD_SEARCH, pick_stored());
        else if (roll < 70)
            send_word(($urandom_range(1) != 0) ? CMD_PREFIX : CMD_SPARE, pick_stored());
        else if (roll < 82)
            send_word(($urandom_range(1) != 0) ? CMD_SEARCH : CMD_PREFIX, pick_word(6, 1'b0));
        else
            send_noise();
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stalls, open in the calm window, closed while the
    // hold-off runs so that the block fills up and stalls its letter input.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || hold_rsp)
                rsp_if.ready <= 1'b0;
            else if (calm)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(99) >= 33);
        end
    end

    initial
    begin
        hold_rsp = 1'b0;
        wait (start_hold);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Guard against a hung handshake; the bound covers the clearing sweep
    // after reset many times over.
    initial
    begin
        #(TIME_LIMIT);
        $display("timeout: %0d letters sent, %0d answers pending", sent, n_pending);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        int base;

        rst_n              = 1'b0;
        calm               = 1'b0;
        start_hold         = 1'b0;
        sent               = 0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_INSERT;
        req_if.letter      = '0;
        req_if.no_letter   = 1'b0;
        req_if.last_letter = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty words at the root: nothing marked yet, then mark it. The
        // empty flag closes the word even without the last-letter mark.
        send_item(CMD_SEARCH, '0, 1'b1, 1'b1);
        send_item(CMD_PREFIX, '0, 1'b1, 1'b0);
        send_item(CMD_INSERT, '0, 1'b1, 1'b1);
        send_item(CMD_SEARCH, '1, 1'b1, 1'b1);

        // Alphabet ends, all three commands and the spare code.
        send_word(CMD_INSERT, spell("a"));
        send_word(CMD_SEARCH, spell("a"));
        send_word(CMD_PREFIX, spell("a"));
        send_word(CMD_INSERT, spell("z"));
        send_word(CMD_SPARE,  spell("z"));

        // Letters past the alphabet fail the walk for any command.
        send_item(CMD_INSERT, '1, 1'b0, 1'b1);
        send_item(CMD_SEARCH, LETTER_W'(ALPHABET_SIZE_DEF), 1'b0, 1'b1);
        send_item(CMD_PREFIX, LETTER_W'(ALPHABET_SIZE_DEF), 1'b0, 1'b1);

        // Mixed commands: the insert letter allocates "b", the search letter
        // cannot extend it; "b" stays as a path without an end mark.
        send_item(CMD_INSERT, LETTER_W'("b" - "a"), 1'b0, 1'b0);
        send_item(CMD_SEARCH, LETTER_W'("c" - "a"), 1'b0, 1'b1);
        send_word(CMD_PREFIX, spell("b"));
        send_word(CMD_SEARCH, spell("b"));

        // Empty flag in the middle of a word ends it at the current node.
        send_item(CMD_INSERT, LETTER_W'("a" - "a"), 1'b0, 1'b0);
        send_item(CMD_SEARCH, '1, 1'b1, 1'b0);

        // Failed insert: later letters are ignored, the answer is overflow.
        send_item(CMD_INSERT, LETTER_W'("a" - "a"), 1'b0, 1'b0);
        send_item(CMD_INSERT, LETTER_W'(30), 1'b0, 1'b0);
        send_item(CMD_INSERT, LETTER_W'("c" - "a"), 1'b0, 1'b1);
        send_word(CMD_PREFIX, spell("ac"));

        stored.push_back(spell("a"));
        stored.push_back(spell("z"));

        // Random words. The hold-off starts right away; a calm window opens
        // partway through so that a long run goes by without idling.
        start_hold <= 1'b1;
        base = sent;
        while (sent - base < RANDOM_ITEMS)
        begin
            calm <= (sent - base >= 250 && sent - base < 350);
            send_random_word();
        end
        calm <= 1'b0;

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run: %0d letter transfers, %0d word answers checked", sent, n_answers);
        $display("run: %0d answers with found set, %0d overflow answers, %0d failures",
                 n_hits, n_overflows, n_errors);
        if (n_errors == 0 && n_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/pte_pkg.sv
rtl/core/pte_if.sv
rtl/core/pte_ram.sv
rtl/core/pte_clear.sv
rtl/core/prefix_trie_engine_core.sv
tb/sv/pte_word_checker.sv
tb/sv/tb_prefix_trie_engine_core.sv
